/* design/strict_u32_hex_dec_parser_unit_defines.svh */
// Assertion macros used by the strict unsigned 32-bit parser top-level design file.
`ifndef STRICT_U32_HEX_DEC_PARSER_UNIT_DEFINES_SVH
`define STRICT_U32_HEX_DEC_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SU32P_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SU32P_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("parser assertion failed");

`endif

/* design/su32p_pkg.sv */
// Package with widths, phase codes, character codes and the digit decoder of the parser.
`timescale 1ns / 1ps
`default_nettype none
package su32p_pkg;

	localparam int CH_W  = 8;
	localparam int ACC_W = 32;
	localparam int DIG_W = 4;
	localparam int PH_W  = 2;

	localparam logic [PH_W-1:0] PH_START = 2'd0;
	localparam logic [PH_W-1:0] PH_ZERO  = 2'd1;
	localparam logic [PH_W-1:0] PH_BODY  = 2'd2;
	localparam logic [PH_W-1:0] PH_FAIL  = 2'd3;

	localparam logic [CH_W-1:0] CH_0     = 8'h30;
	localparam logic [CH_W-1:0] CH_9     = 8'h39;
	localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_F  = 8'h66;
	localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_F  = 8'h46;
	localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;

	typedef struct packed {
		logic             bad;
		logic [DIG_W-1:0] val;
	} digit_t;

	// Decodes one character; letters count as digits only in hex mode.
	function automatic digit_t digit_of(input logic [CH_W-1:0] c, input logic hex);
		digit_t d;
		logic [CH_W-1:0] off;
		d.bad = 1'b1;
		d.val = '0;
		off   = '0;
		if (c >= CH_0 && c <= CH_9) begin
			off   = c - CH_0;
			d.bad = 1'b0;
			d.val = off[DIG_W-1:0];
		end else if (hex && c >= CH_LO_A && c <= CH_LO_F) begin
			off   = c - CH_LO_A + 8'd10;
			d.bad = 1'b0;
			d.val = off[DIG_W-1:0];
		end else if (hex && c >= CH_UP_A && c <= CH_UP_F) begin
			off   = c - CH_UP_A + 8'd10;
			d.bad = 1'b0;
			d.val = off[DIG_W-1:0];
		end
		return d;
	endfunction

endpackage
`default_nettype wire

/* design/su32p_if.sv */
// Valid/ready channel interfaces for character requests and parse results.
`timescale 1ns / 1ps
`default_nettype none
interface su32p_char_if import su32p_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            end_of_string;

	modport source (output valid, output ch, output end_of_string, input ready);
	modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

interface su32p_result_if import su32p_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             ok;
	logic [ACC_W-1:0] value;

	modport source (output valid, output ok, output value, input ready);
	modport sink   (input valid, input ok, input value, output ready);
endinterface
`default_nettype wire

/* design/strict_u32_hex_dec_parser_unit.sv */
// Top level of the streaming strict unsigned 32-bit hex/decimal string parser.
// Each request carries one character, or the end mark of a string; a request is taken
// into an input register and from there updates the 32-bit accumulator in a single
// pass (a 4-bit shift in hex mode, a multiply by ten plus add in decimal mode, with the
// overflow check on the same sum). A new request is accepted every cycle; only an end
// request whose result finds the result register still full waits for it to drain. The
// result (ok, value) is registered as the end request leaves the input register, and
// the parser returns to its start state for the next string.
`timescale 1ns / 1ps
`default_nettype none
`include "strict_u32_hex_dec_parser_unit_defines.svh"
module strict_u32_hex_dec_parser_unit import su32p_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	su32p_char_if.sink     char_req,
	su32p_result_if.source result
);

	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            end_s1;

	logic [ACC_W-1:0] acc_q, acc_d;
	logic [PH_W-1:0]  phase_q, phase_d;
	logic             hex_q, hex_d;
	logic             saw_q, saw_d;

	logic             res_valid_q;
	logic             res_ok_q;
	logic [ACC_W-1:0] res_value_q;

	logic               advance;
	logic               take_in;
	digit_t             dig;
	logic [ACC_W+3:0]   dec_sum;
	logic               is_x;
	logic               str_ok;

	// An end request may only move on once the result register has room.
	assign advance = valid_s1 && (!end_s1 || !res_valid_q || result.ready);
	assign take_in = char_req.valid && char_req.ready;
	assign char_req.ready = !valid_s1 || advance;

	assign dig  = digit_of(ch_s1, hex_q);
	assign is_x = (ch_s1 == CH_LO_X) || (ch_s1 == CH_UP_X);
	assign dec_sum = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
		+ {{(ACC_W){1'b0}}, dig.val};
	assign str_ok = (phase_q != PH_FAIL) && saw_q;

	always_comb begin
		acc_d   = acc_q;
		phase_d = phase_q;
		hex_d   = hex_q;
		saw_d   = saw_q;
		priority if (end_s1) begin
			acc_d   = '0;
			phase_d = PH_START;
			hex_d   = 1'b0;
			saw_d   = 1'b0;
		end else if (phase_q == PH_FAIL) begin
			phase_d = PH_FAIL;
		end else if (phase_q == PH_ZERO && is_x) begin
			acc_d   = '0;
			phase_d = PH_BODY;
			hex_d   = 1'b1;
			saw_d   = 1'b0;
		end else if (dig.bad) begin
			phase_d = PH_FAIL;
		end else if (hex_q) begin
			if (acc_q[ACC_W-1 -: DIG_W] != '0) begin
				phase_d = PH_FAIL;
			end else begin
				acc_d   = {acc_q[ACC_W-DIG_W-1:0], dig.val};
				saw_d   = 1'b1;
				phase_d = PH_BODY;
			end
		end else begin
			// Anything above 32 bits in the sum covers both the multiply and the add overflow.
			if (dec_sum[ACC_W+3:ACC_W] != '0) begin
				phase_d = PH_FAIL;
			end else begin
				acc_d   = dec_sum[ACC_W-1:0];
				saw_d   = 1'b1;
				phase_d = (phase_q == PH_START && ch_s1 == CH_0) ? PH_ZERO : PH_BODY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_req.ready) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			ch_s1  <= char_req.ch;
			end_s1 <= char_req.end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= PH_START;
			hex_q   <= 1'b0;
			saw_q   <= 1'b0;
		end else if (advance) begin
			acc_q   <= acc_d;
			phase_q <= phase_d;
			hex_q   <= hex_d;
			saw_q   <= saw_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			res_ok_q    <= str_ok;
			res_value_q <= str_ok ? acc_q : '0;
		end
	end

	assign result.valid = res_valid_q;
	assign result.ok    = res_ok_q;
	assign result.value = res_value_q;

	`SU32P_ASSERT_IMP(a_fail_value_zero, clk, arst_n, result.valid && !result.ok, result.value == '0)
	`SU32P_ASSERT_IMP(a_start_clean, clk, arst_n, phase_q == PH_START, acc_q == '0 && !saw_q && !hex_q)
	`SU32P_ASSERT_IMP(a_zero_decimal, clk, arst_n, phase_q == PH_ZERO, acc_q == '0 && saw_q && !hex_q)
	`SU32P_ASSERT_IMP(a_hex_in_body, clk, arst_n, hex_q, phase_q == PH_BODY || phase_q == PH_FAIL)
	`SU32P_ASSERT_NXT(a_end_resets, clk, arst_n, advance && end_s1, phase_q == PH_START && result.valid)

endmodule
`default_nettype wire
